@@ rtl/dtd_pkg.sv @@
// Shared types, constants and helpers of the decimal text to double parser.
`default_nettype none

package dtd_pkg;

   localparam int EXP_LIMIT_DEF = 511;

   localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_LO_E  = 8'h65;

   localparam logic [3:0] TEN = 4'd10;

   typedef enum logic [1:0] {
      FOP_MUL,
      FOP_ADD,
      FOP_DIV10
   } fpu_op_type;

   typedef struct packed {
      logic       start;
      fpu_op_type op;
      logic [3:0] k;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } fpu_rsp_type;

   // exact double of a decimal digit
   function automatic logic [63:0] digit_to_double(input logic [3:0] d);
      logic [63:0] r;
      unique case (d)
         4'd1:    r = 64'h3FF0_0000_0000_0000;
         4'd2:    r = 64'h4000_0000_0000_0000;
         4'd3:    r = 64'h4008_0000_0000_0000;
         4'd4:    r = 64'h4010_0000_0000_0000;
         4'd5:    r = 64'h4014_0000_0000_0000;
         4'd6:    r = 64'h4018_0000_0000_0000;
         4'd7:    r = 64'h401C_0000_0000_0000;
         4'd8:    r = 64'h4020_0000_0000_0000;
         4'd9:    r = 64'h4022_0000_0000_0000;
         default: r = DBL_ZERO;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dtd_fpu.sv @@
// Iterative double unit for non-negative operands: a*k, a+b and a/10, round to nearest even.
`default_nettype none

module dtd_fpu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dtd_pkg::fpu_req_type req_in,
   input  wire logic [63:0]         opa,
   input  wire logic [63:0]         opb,
   output dtd_pkg::fpu_rsp_type     rsp_out
);
   import dtd_pkg::*;

   localparam int SW = 64;
   localparam int XW = 13;
   localparam int DW = 68;
   localparam logic [4:0] DIV_STEPS = 5'd17;

   typedef enum logic [2:0] {
      F_IDLE,
      F_ALIGN,
      F_DIV,
      F_NORM,
      F_PACK,
      F_ROUND
   } fstate_type;

   fstate_type           state_ff, state_in;
   logic [SW-1:0]        sig_ff, sig_in;
   logic [SW-1:0]        lo_ff, lo_in;
   logic signed [XW-1:0] exp_ff, exp_in;
   logic [6:0]           sh_ff, sh_in;
   logic                 sticky_ff, sticky_in;
   logic [DW-1:0]        divd_ff, divd_in;
   logic [3:0]           rem_ff, rem_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [62:0]          pre_ff, pre_in;
   logic                 up_ff, up_in;
   logic [63:0]          result_ff, result_in;
   logic                 done_ff, done_in;

   // operand unpack
   logic [10:0]          ea, eb;
   logic [52:0]          ma, mb, hi_m, lo_m;
   logic signed [XW-1:0] xa, xb, hi_x, lo_x, diff, be, dsh;
   logic                 a_inf, b_inf, a_ge_b;
   logic [56:0]          mul_prod;
   logic [SW-1:0]        shifted, s2;
   logic                 lost, st2;
   logic [7:0]           dx;
   logic [15:0]          dprod;
   logic [3:0]           dq;
   logic [7:0]           drem;
   logic [6:0]           psh;
   logic [10:0]          field;

   assign ea     = opa[62:52];
   assign eb     = opb[62:52];
   assign ma     = {(ea != 11'd0), opa[51:0]};
   assign mb     = {(eb != 11'd0), opb[51:0]};
   assign xa     = ((ea == 11'd0) ? 13'sd1 : $signed({2'b00, ea})) - 13'sd1075;
   assign xb     = ((eb == 11'd0) ? 13'sd1 : $signed({2'b00, eb})) - 13'sd1075;
   assign a_inf  = &ea;
   assign b_inf  = &eb;
   assign a_ge_b = opa[62:0] >= opb[62:0];
   assign hi_m   = a_ge_b ? ma : mb;
   assign lo_m   = a_ge_b ? mb : ma;
   assign hi_x   = a_ge_b ? xa : xb;
   assign lo_x   = a_ge_b ? xb : xa;
   assign diff   = hi_x - lo_x;
   assign mul_prod = 57'(ma) * 57'(req_in.k);

   // divide by ten, one nibble per step; q = x*205 >> 11 is exact for x < 160
   assign dx    = {rem_ff, divd_ff[DW-1 -: 4]};
   assign dprod = 16'(dx) * 16'd205;
   assign dq    = dprod[14:11];
   assign drem  = dx - 8'(dq) * 8'(TEN);

   assign be  = exp_ff + 13'sd1086;
   assign dsh = 13'sd1 - be;
   assign psh = (dsh > 13'sd64) ? 7'd64 : dsh[6:0];

   always_comb begin
      shifted = '0;
      lost    = 1'b0;
      s2      = sig_ff;
      st2     = sticky_ff;
      field   = be[10:0];
      if (state_ff == F_ALIGN) begin
         shifted = lo_ff >> sh_ff;
         lost    = |(lo_ff & ~({SW{1'b1}} << sh_ff));
      end else if (be <= 13'sd0) begin
         s2    = sig_ff >> psh;
         st2   = sticky_ff | (|(sig_ff & ~({SW{1'b1}} << psh)));
         field = 11'd0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sig_in    = sig_ff;
      lo_in     = lo_ff;
      exp_in    = exp_ff;
      sh_in     = sh_ff;
      sticky_in = sticky_ff;
      divd_in   = divd_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      pre_in    = pre_ff;
      up_in     = up_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_in.start) begin
               sticky_in = 1'b0;
               unique case (req_in.op)
                  FOP_MUL: begin
                     if (a_inf) begin
                        result_in = DBL_INF;
                        done_in   = 1'b1;
                     end else begin
                        sig_in   = {mul_prod, 7'd0};
                        exp_in   = xa - 13'sd7;
                        state_in = F_NORM;
                     end
                  end
                  FOP_ADD: begin
                     if (a_inf || b_inf) begin
                        result_in = DBL_INF;
                        done_in   = 1'b1;
                     end else begin
                        sig_in   = {1'b0, hi_m, 10'd0};
                        lo_in    = {1'b0, lo_m, 10'd0};
                        exp_in   = hi_x - 13'sd10;
                        sh_in    = (diff > 13'sd64) ? 7'd64 : diff[6:0];
                        state_in = F_ALIGN;
                     end
                  end
                  FOP_DIV10: begin
                     if (a_inf) begin
                        result_in = DBL_INF;
                        done_in   = 1'b1;
                     end else begin
                        divd_in  = {1'b0, ma, 14'd0};
                        rem_in   = 4'd0;
                        cnt_in   = DIV_STEPS;
                        sig_in   = '0;
                        exp_in   = xa - 13'sd14;
                        state_in = F_DIV;
                     end
                  end
                  default: begin
                     result_in = DBL_ZERO;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         F_ALIGN: begin
            sig_in    = sig_ff + shifted;
            sticky_in = lost;
            state_in  = F_NORM;
         end
         F_DIV: begin
            sig_in  = {sig_ff[SW-5:0], dq};
            divd_in = divd_ff << 4;
            rem_in  = drem[3:0];
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               sticky_in = (drem != 8'd0);
               state_in  = F_NORM;
            end
         end
         F_NORM: begin
            priority if (sig_ff == '0) begin
               result_in = DBL_ZERO;
               done_in   = 1'b1;
               state_in  = F_IDLE;
            end else if (sig_ff[SW-1 -: 8] == 8'd0) begin
               sig_in = sig_ff << 8;
               exp_in = exp_ff - 13'sd8;
            end else if (!sig_ff[SW-1]) begin
               sig_in = sig_ff << 1;
               exp_in = exp_ff - 13'sd1;
            end else begin
               state_in = F_PACK;
            end
         end
         F_PACK: begin
            if (be >= 13'sd2047) begin
               result_in = DBL_INF;
               done_in   = 1'b1;
               state_in  = F_IDLE;
            end else begin
               pre_in   = {field, s2[62:11]};
               up_in    = s2[10] & (s2[11] | (|s2[9:0]) | st2);
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            // carry out of the fraction steps the exponent, up to infinity
            result_in = {1'b0, pre_ff + 63'(up_ff)};
            done_in   = 1'b1;
            state_in  = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      sig_ff    <= sig_in;
      lo_ff     <= lo_in;
      exp_ff    <= exp_in;
      sh_ff     <= sh_in;
      sticky_ff <= sticky_in;
      divd_ff   <= divd_in;
      rem_ff    <= rem_in;
      pre_ff    <= pre_in;
      up_ff     <= up_in;
      result_ff <= result_in;
   end

   assign rsp_out.done   = done_ff;
   assign rsp_out.result = result_ff;

endmodule

`default_nettype wire

@@ rtl/decimal_text_to_double.sv @@
// Top level: streaming ASCII decimal to IEEE double parser.
//
// Input stream takes one character per transfer: req_tdata[7:0] is the byte,
// req_tlast marks end of input (byte ignored). Leading whitespace is skipped,
// then sign, integer digits, '.', fraction digits and E/e with signed exponent.
// One result transfer per number: rsp_tdata is the double bit pattern,
// rsp_tuser[0] flags input that held only whitespace, rsp_tuser[1]
// says the terminating byte was not consumed and must be offered again.
// csr_wr_en/csr_wr_data set max_digits (reset 255); write only when idle.
// Plain characters are taken without arithmetic. All arithmetic goes through one
// shared iterative double unit (dtd_fpu), which does a multiply, an add or a
// divide by ten (one nibble per step). An integer digit costs a multiply and an
// add, a fraction digit a divide, a multiply and an add. At the end of a
// number the exponent is applied one power of ten per unit operation, a
// multiply (positive) or a divide (negative) per exponent unit. req_tready is
// low while the unit is busy.
// A stalled result waits in the output register; parsing goes on and only
// the next result waits for the register to free. Reset is synchronous and
// returns to whitespace skipping with max_digits 255 and no result pending.
`default_nettype none

module decimal_text_to_double #(
   parameter int EXP_LIMIT = dtd_pkg::EXP_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_in
   input  wire logic        req_tlast,    // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // [63:0] number_bits
   output logic [1:0]       rsp_tuser,    // [0] status, [1] push_back
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data   // max_digits
);
   import dtd_pkg::*;

   localparam int EW  = $clog2(EXP_LIMIT + 1);
   localparam int EPW = EW + 4;

   typedef enum logic [3:0] {
      T_IDLE,
      T_INT_MUL,
      T_INT_ADD,
      T_FRAC_DIV,
      T_FRAC_MUL,
      T_FRAC_ADD,
      T_SCALE,
      T_SCALE_WAIT,
      T_EMIT
   } tstate_type;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_INT,
      PH_FRAC,
      PH_ESIGN,
      PH_EXP
   } phase_type;

   tstate_type  state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [63:0] accum_ff, accum_in;
   logic [63:0] fw_ff, fw_in;          // fraction weight
   logic [EW-1:0] expcnt_ff, expcnt_in;
   logic        expneg_ff, expneg_in;
   logic        sign_ff, sign_in;
   logic [7:0]  digcnt_ff, digcnt_in;
   logic [7:0]  maxdig_ff, maxdig_in;
   logic [3:0]  digit_ff, digit_in;
   logic        stop_ff, stop_in;      // digit limit reached, finish after arithmetic
   logic        status_ff, status_in;
   logic        push_ff, push_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   fpu_req_type fpu_req_ff, fpu_req_in;
   logic [63:0] fpu_a_ff, fpu_a_in;
   logic [63:0] fpu_b_ff, fpu_b_in;
   fpu_rsp_type fpu_rsp;

   logic [7:0]   ch;
   logic         is_sp, is_dg;
   logic [EPW-1:0] e_next;
   logic [EW-1:0]  e_sat;
   logic [7:0]   digcnt_inc;

   assign ch    = req_tdata;
   assign is_sp = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_dg = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign e_next = EPW'(expcnt_ff) * EPW'(TEN) + EPW'(ch[3:0]);
   assign e_sat  = (e_next > EPW'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : e_next[EW-1:0];
   assign digcnt_inc = digcnt_ff + 8'd1;

   dtd_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .req_in  (fpu_req_ff),
      .opa     (fpu_a_ff),
      .opb     (fpu_b_ff),
      .rsp_out (fpu_rsp)
   );

   always_comb begin
      phase_type ph_e;
      logic      used;
      state_in     = state_ff;
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      fw_in        = fw_ff;
      expcnt_in    = expcnt_ff;
      expneg_in    = expneg_ff;
      sign_in      = sign_ff;
      digcnt_in    = digcnt_ff;
      maxdig_in    = maxdig_ff;
      digit_in     = digit_ff;
      stop_in      = stop_ff;
      status_in    = status_ff;
      push_in      = push_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      fpu_req_in   = fpu_req_ff;
      fpu_req_in.start = 1'b0;
      fpu_a_in     = fpu_a_ff;
      fpu_b_in     = fpu_b_ff;
      ph_e         = phase_ff;
      used         = 1'b0;

      if (csr_wr_en) begin
         maxdig_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         T_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  status_in = (phase_ff == PH_SKIP);
                  push_in   = 1'b0;
                  state_in  = (phase_ff == PH_SKIP) ? T_EMIT : T_SCALE;
               end else begin
                  if (ph_e == PH_SKIP) begin
                     if (is_sp) begin
                        used = 1'b1;
                     end else begin
                        ph_e = PH_INT;
                        if (ch == CH_MINUS) begin
                           sign_in = 1'b1;
                           used    = 1'b1;
                        end else if (ch == CH_PLUS) begin
                           used = 1'b1;
                        end
                     end
                  end
                  if (!used && ph_e == PH_ESIGN) begin
                     ph_e = PH_EXP;
                     if (ch == CH_MINUS) begin
                        expneg_in = 1'b1;
                        used      = 1'b1;
                     end else if (ch == CH_PLUS) begin
                        used = 1'b1;
                     end
                  end
                  phase_in = ph_e;
                  if (!used) begin
                     status_in = 1'b0;
                     push_in   = 1'b0;
                     priority if (is_dg) begin
                        if (digcnt_ff >= maxdig_ff) begin
                           push_in  = 1'b1;
                           state_in = T_SCALE;
                        end else begin
                           digcnt_in = digcnt_inc;
                           stop_in   = (digcnt_inc >= maxdig_ff);
                           digit_in  = ch[3:0];
                           if (ph_e == PH_INT) begin
                              fpu_req_in.start = 1'b1;
                              fpu_req_in.op    = FOP_MUL;
                              fpu_req_in.k     = TEN;
                              fpu_a_in         = accum_ff;
                              state_in         = T_INT_MUL;
                           end else if (ph_e == PH_FRAC) begin
                              fpu_req_in.start = 1'b1;
                              fpu_req_in.op    = FOP_DIV10;
                              fpu_a_in         = fw_ff;
                              state_in         = T_FRAC_DIV;
                           end else begin
                              expcnt_in = e_sat;
                              if (digcnt_inc >= maxdig_ff) begin
                                 state_in = T_SCALE;
                              end
                           end
                        end
                     end else if (ph_e == PH_INT && ch == CH_DOT) begin
                        phase_in = PH_FRAC;
                     end else if ((ph_e == PH_INT || ph_e == PH_FRAC) &&
                                  (ch == CH_UP_E || ch == CH_LO_E)) begin
                        phase_in = PH_ESIGN;
                     end else begin
                        push_in  = 1'b1;
                        state_in = T_SCALE;
                     end
                  end
               end
            end
         end
         T_INT_MUL: begin
            if (fpu_rsp.done) begin
               fpu_req_in.start = 1'b1;
               fpu_req_in.op    = FOP_ADD;
               fpu_a_in         = fpu_rsp.result;
               fpu_b_in         = digit_to_double(digit_ff);
               state_in         = T_INT_ADD;
            end
         end
         T_FRAC_DIV: begin
            if (fpu_rsp.done) begin
               fw_in            = fpu_rsp.result;
               fpu_req_in.start = 1'b1;
               fpu_req_in.op    = FOP_MUL;
               fpu_req_in.k     = digit_ff;
               fpu_a_in         = fpu_rsp.result;
               state_in         = T_FRAC_MUL;
            end
         end
         T_FRAC_MUL: begin
            if (fpu_rsp.done) begin
               fpu_req_in.start = 1'b1;
               fpu_req_in.op    = FOP_ADD;
               fpu_a_in         = accum_ff;
               fpu_b_in         = fpu_rsp.result;
               state_in         = T_FRAC_ADD;
            end
         end
         T_INT_ADD, T_FRAC_ADD: begin
            if (fpu_rsp.done) begin
               accum_in = fpu_rsp.result;
               state_in = stop_ff ? T_SCALE : T_IDLE;
            end
         end
         T_SCALE: begin
            if (expcnt_ff == '0) begin
               state_in = T_EMIT;
            end else begin
               fpu_req_in.start = 1'b1;
               fpu_req_in.op    = expneg_ff ? FOP_DIV10 : FOP_MUL;
               fpu_req_in.k     = TEN;
               fpu_a_in         = accum_ff;
               state_in         = T_SCALE_WAIT;
            end
         end
         T_SCALE_WAIT: begin
            if (fpu_rsp.done) begin
               accum_in  = fpu_rsp.result;
               expcnt_in = expcnt_ff - EW'(1);
               state_in  = T_SCALE;
            end
         end
         T_EMIT: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = status_ff ? DBL_ZERO : {sign_ff, accum_ff[62:0]};
               rsp_user_in  = {push_ff, status_ff};
               phase_in     = PH_SKIP;
               accum_in     = DBL_ZERO;
               fw_in        = DBL_ONE;
               expcnt_in    = '0;
               expneg_in    = 1'b0;
               sign_in      = 1'b0;
               digcnt_in    = 8'd0;
               stop_in      = 1'b0;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         phase_ff     <= PH_SKIP;
         accum_ff     <= DBL_ZERO;
         fw_ff        <= DBL_ONE;
         expcnt_ff    <= '0;
         expneg_ff    <= 1'b0;
         sign_ff      <= 1'b0;
         digcnt_ff    <= 8'd0;
         maxdig_ff    <= 8'd255;
         stop_ff      <= 1'b0;
         status_ff    <= 1'b0;
         push_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fpu_req_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         fw_ff        <= fw_in;
         expcnt_ff    <= expcnt_in;
         expneg_ff    <= expneg_in;
         sign_ff      <= sign_in;
         digcnt_ff    <= digcnt_in;
         maxdig_ff    <= maxdig_in;
         stop_ff      <= stop_in;
         status_ff    <= status_in;
         push_ff      <= push_in;
         rsp_valid_ff <= rsp_valid_in;
         fpu_req_ff   <= fpu_req_in;
      end
      digit_ff    <= digit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      fpu_a_ff    <= fpu_a_in;
      fpu_b_ff    <= fpu_b_in;
   end

   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // no-input results carry a zero value and never a pushed-back byte
   a_no_input_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff == DBL_ZERO && !rsp_user_ff[1]))
      else $error("no-input result with value or push-back");

   // a freshly loaded result leaves the number state cleared
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (phase_ff == PH_SKIP && digcnt_ff == 8'd0 && !sign_ff))
      else $error("number state not cleared after result");

   // the arithmetic unit is only started from a busy state
   a_fpu_start_busy: assert property (@(posedge clock) disable iff (reset)
      fpu_req_ff.start |-> (state_ff != T_IDLE && state_ff != T_EMIT))
      else $error("arithmetic unit started while idle");

   a_exp_saturated: assert property (@(posedge clock) disable iff (reset)
      expcnt_ff <= EW'(EXP_LIMIT))
      else $error("exponent count above limit");

endmodule

`default_nettype wire
